/* rtl/debounced_toggle_crc8_frame_sender_core_defines.svh */
// assertion macros for the debounced toggle crc8 frame sender
// used by the port checker; no other dependencies
`ifndef DEBOUNCED_TOGGLE_CRC8_FRAME_SENDER_CORE_DEFINES_SVH
`define DEBOUNCED_TOGGLE_CRC8_FRAME_SENDER_CORE_DEFINES_SVH

// same-cycle implication
`define DTCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dtcs_pkg.sv */
// shared types, constants and crc helper for the frame sender
// no dependencies
package dtcs_pkg;

	localparam int FRAME_BYTES = 6;

	localparam logic [7:0] HDR_BYTE0 = 8'hA6;
	localparam logic [7:0] HDR_BYTE1 = 8'h12;
	localparam logic [7:0] HDR_BYTE2 = 8'h02;
	localparam logic [7:0] CRC_POLY  = 8'h8C;
	localparam logic [7:0] CRC_INIT  = 8'h00;

	localparam logic [7:0]  RST_OPTION_FLAGS   = 8'd241;
	localparam logic [7:0]  RST_SPEED_LIMIT    = 8'd255;
	localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd20;
	localparam logic [15:0] RST_RESEND_PERIOD  = 16'd500;

	localparam logic [7:0]  TICKS_MAX  = 8'hFF;
	localparam logic [15:0] RESEND_MAX = 16'hFFFF;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [2:0] IDX_HDR0  = 3'd0;
	localparam logic [2:0] IDX_HDR1  = 3'd1;
	localparam logic [2:0] IDX_HDR2  = 3'd2;
	localparam logic [2:0] IDX_FLAGS = 3'd3;
	localparam logic [2:0] IDX_SPEED = 3'd4;
	localparam logic [2:0] IDX_CRC   = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPTION_FLAGS   = 2'd0,
		CFG_SPEED_LIMIT    = 2'd1,
		CFG_DEBOUNCE_TICKS = 2'd2,
		CFG_RESEND_PERIOD  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BEEP_NONE = 2'd0,
		BEEP_HIGH = 2'd1,
		BEEP_LOW  = 2'd2
	} beep_t;

	typedef struct packed {
		logic [7:0] flags;
		logic [7:0] speed;
		beep_t      beep;
	} frame_desc_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

/* rtl/dtcs_front.sv */
// front part: config registers, debounce, toggle and send decision per tick
// depends on dtcs_pkg
module dtcs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [dtcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_level,
	input  logic                             q_full,
	output logic                             q_push,
	output dtcs_pkg::frame_desc_t            q_data
);

	logic [7:0]  option_flags_q;
	logic [7:0]  speed_limit_q;
	logic [7:0]  debounce_ticks_q;
	logic [15:0] resend_period_q;

	logic        light_on_q;
	logic        debounced_level_q;
	logic        prev_level_q;
	logic        edge_pending_q;
	logic [7:0]  ticks_q;
	logic [15:0] resend_q;
	logic        send_pending_q;

	logic        accept;
	logic        edge_n;
	logic [7:0]  ticks_inc;
	logic        sample;
	logic        toggle;
	logic        release_smp;
	logic        light_n;
	logic        send;
	logic [15:0] resend_inc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign edge_n      = edge_pending_q || (button_level != prev_level_q);
	assign ticks_inc   = (ticks_q != dtcs_pkg::TICKS_MAX) ? ticks_q + 8'd1 : ticks_q;
	assign sample      = (ticks_inc > debounce_ticks_q) && edge_n;
	assign toggle      = sample && !button_level && debounced_level_q;
	assign release_smp = sample && button_level && !debounced_level_q;
	assign light_n     = light_on_q ^ toggle;
	assign send        = (resend_q >= resend_period_q) || send_pending_q || toggle;
	assign resend_inc  = (resend_q != dtcs_pkg::RESEND_MAX) ? resend_q + 16'd1 : resend_q;

	assign q_push = accept && send;

	always_comb begin
		q_data.flags = {option_flags_q[7:3], light_n, option_flags_q[1:0]};
		q_data.speed = speed_limit_q;
		if (toggle)
			q_data.beep = light_n ? dtcs_pkg::BEEP_HIGH : dtcs_pkg::BEEP_LOW;
		else
			q_data.beep = dtcs_pkg::BEEP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_flags_q   <= dtcs_pkg::RST_OPTION_FLAGS;
			speed_limit_q    <= dtcs_pkg::RST_SPEED_LIMIT;
			debounce_ticks_q <= dtcs_pkg::RST_DEBOUNCE_TICKS;
			resend_period_q  <= dtcs_pkg::RST_RESEND_PERIOD;
		end else if (cfg_valid) begin
			case (cfg_index)
				dtcs_pkg::CFG_OPTION_FLAGS:   option_flags_q   <= cfg_data[7:0];
				dtcs_pkg::CFG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[7:0];
				dtcs_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[7:0];
				dtcs_pkg::CFG_RESEND_PERIOD:  resend_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_on_q        <= 1'b1;
			debounced_level_q <= 1'b1;
			prev_level_q      <= 1'b1;
			edge_pending_q    <= 1'b0;
			ticks_q           <= '0;
			resend_q          <= '0;
			send_pending_q    <= 1'b1;
		end else if (accept) begin
			prev_level_q   <= button_level;
			edge_pending_q <= sample ? 1'b0 : edge_n;
			ticks_q        <= sample ? 8'd0 : ticks_inc;
			light_on_q     <= light_n;
			if (toggle)
				debounced_level_q <= 1'b0;
			else if (release_smp)
				debounced_level_q <= 1'b1;
			send_pending_q <= 1'b0;
			resend_q       <= send ? 16'd1 : resend_inc;
		end
	end

endmodule

/* rtl/dtcs_queue.sv */
// short frame descriptor queue between front and back
// depends on dtcs_pkg
module dtcs_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dtcs_pkg::frame_desc_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output dtcs_pkg::frame_desc_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	dtcs_pkg::frame_desc_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* rtl/dtcs_back.sv */
// back part: serializes one frame per descriptor and accumulates the crc
// depends on dtcs_pkg
module dtcs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  dtcs_pkg::frame_desc_t q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            frame_byte,
	output logic [2:0]            byte_index,
	output logic                  last_of_frame,
	output logic [1:0]            beep
);

	logic                  cur_valid_q;
	dtcs_pkg::frame_desc_t cur_q;
	logic [2:0]            idx_q;
	logic [7:0]            crc_q;
	logic                  xfer;
	logic                  last;
	logic [7:0]            byte_n;

	assign last = (idx_q == dtcs_pkg::IDX_CRC);
	assign xfer = cur_valid_q && !out_stall;
	assign q_pop = q_not_empty && (!cur_valid_q || (xfer && last));

	always_comb begin
		case (idx_q)
			dtcs_pkg::IDX_HDR0:  byte_n = dtcs_pkg::HDR_BYTE0;
			dtcs_pkg::IDX_HDR1:  byte_n = dtcs_pkg::HDR_BYTE1;
			dtcs_pkg::IDX_HDR2:  byte_n = dtcs_pkg::HDR_BYTE2;
			dtcs_pkg::IDX_FLAGS: byte_n = cur_q.flags;
			dtcs_pkg::IDX_SPEED: byte_n = cur_q.speed;
			default:             byte_n = crc_q;
		endcase
	end

	assign out_valid     = cur_valid_q;
	assign frame_byte    = byte_n;
	assign byte_index    = idx_q;
	assign last_of_frame = last;
	assign beep          = (idx_q == dtcs_pkg::IDX_HDR0) ? cur_q.beep : dtcs_pkg::BEEP_NONE;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			crc_q       <= dtcs_pkg::CRC_INIT;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= dtcs_pkg::IDX_HDR0;
			crc_q       <= dtcs_pkg::CRC_INIT;
		end else if (xfer) begin
			if (last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
				crc_q <= dtcs_pkg::crc8_byte(crc_q, byte_n);
			end
		end
	end

endmodule

/* rtl/debounced_toggle_crc8_frame_sender_core.sv */
// top level of the debounced toggle crc8 frame sender
// depends on dtcs_pkg, dtcs_front, dtcs_queue, dtcs_back
//
//  channel | signals                                           | handshake
//  --------+---------------------------------------------------+----------------
//  in      | button_level                                      | in_valid/in_stall
//  out     | frame_byte, byte_index, last_of_frame, beep       | out_valid/out_stall
//  cfg     | cfg_index, cfg_data                               | cfg_valid/cfg_ready
//
// a tick is taken every cycle while the descriptor queue has room; a tick that sends
// queues one descriptor and the back end then serializes the six-byte frame, one byte
// a cycle while out_stall is low, taking the next descriptor as the crc byte goes out
// output stalls fill the queue and then raise in_stall; cfg_ready is always high
// reset is asynchronous and immediate, no clearing pass
module debounced_toggle_crc8_frame_sender_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dtcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             button_level,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       frame_byte,
	output logic [2:0]                       byte_index,
	output logic                             last_of_frame,
	output logic [1:0]                       beep
);

	logic                  q_push;
	logic                  q_full;
	logic                  q_pop;
	logic                  q_not_empty;
	dtcs_pkg::frame_desc_t q_wdata;
	dtcs_pkg::frame_desc_t q_rdata;

	assign cfg_ready = 1'b1;

	dtcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	dtcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	dtcs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_data        (q_rdata),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.byte_index    (byte_index),
		.last_of_frame (last_of_frame),
		.beep          (beep)
	);

endmodule

/* rtl/dtcs_checker.sv */
// port-level checker for the frame sender, bound to the top level
// depends on debounced_toggle_crc8_frame_sender_core_defines.svh and dtcs_pkg
`include "debounced_toggle_crc8_frame_sender_core_defines.svh"

module dtcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic [2:0] byte_index,
	input logic       last_of_frame,
	input logic [1:0] beep
);

	`DTCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(frame_byte) && $stable(byte_index), "stalled output changed")
	`DTCS_ASSERT_IMP(a_last_pos, clk, arst_n, out_valid, last_of_frame == (byte_index == dtcs_pkg::IDX_CRC), "last flag off the crc byte")
	`DTCS_ASSERT_NEXT(a_idx_seq, clk, arst_n, out_valid && !out_stall && !last_of_frame, out_valid && (byte_index == $past(byte_index) + 3'd1), "frame byte order broken")
	`DTCS_ASSERT_IMP(a_beep_first, clk, arst_n, out_valid && (byte_index != dtcs_pkg::IDX_HDR0), beep == dtcs_pkg::BEEP_NONE, "beep outside first byte")
	`DTCS_ASSERT_IMP(a_header, clk, arst_n, out_valid && (byte_index == dtcs_pkg::IDX_HDR0), frame_byte == dtcs_pkg::HDR_BYTE0, "bad frame header")

endmodule

bind debounced_toggle_crc8_frame_sender_core dtcs_checker u_dtcs_checker (.*);

/* sim/dtcs_frame_checker.sv */
// checker for the debounced toggle crc8 frame sender: tracks the tick, config and
// frame byte transfers, predicts every frame byte and compares in order
// depends on dtcs_pkg
module dtcs_frame_checker
	import dtcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  button_level,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [7:0]            frame_byte,
	input  logic [2:0]            byte_index,
	input  logic                  last_of_frame,
	input  logic [1:0]            beep,
	output int                    mismatches,
	output int                    pending_bytes,
	output int                    ticks_seen,
	output int                    bytes_checked,
	output int                    toggles_seen
);

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] pos;
		logic       last;
		beep_t      tone;
	} frame_entry_t;

	frame_entry_t expected_bytes[$];

	logic [7:0]  flags_reg;
	logic [7:0]  speed_reg;
	logic [7:0]  debounce_reg;
	logic [15:0] period_reg;

	logic        lamp_on;
	logic        stable_level;
	logic        last_raw;
	logic        edge_seen;
	logic [7:0]  since_sample;
	logic [15:0] repeat_count;
	logic        send_due;

	int err_count;
	int tick_count;
	int byte_count;
	int toggle_count;

	function automatic logic [7:0] maxim_crc(input logic [4:0][7:0] body);
		logic [7:0] acc;
		logic       fb;
		acc = CRC_INIT;
		for (int k = 0; k < FRAME_BYTES - 1; k++) begin
			for (int b = 0; b < 8; b++) begin
				fb = acc[0] ^ body[k][b];
				acc = {1'b0, acc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
			end
		end
		return acc;
	endfunction

	task automatic reset_model();
		flags_reg = RST_OPTION_FLAGS;
		speed_reg = RST_SPEED_LIMIT;
		debounce_reg = RST_DEBOUNCE_TICKS;
		period_reg = RST_RESEND_PERIOD;
		lamp_on = 1'b1;
		stable_level = 1'b1;
		last_raw = 1'b1;
		edge_seen = 1'b0;
		since_sample = 8'd0;
		repeat_count = 16'd0;
		send_due = 1'b1;
		expected_bytes.delete();
		err_count = 0;
		tick_count = 0;
		byte_count = 0;
		toggle_count = 0;
	endtask

	task automatic apply_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			CFG_OPTION_FLAGS:   flags_reg = value[7:0];
			CFG_SPEED_LIMIT:    speed_reg = value[7:0];
			CFG_DEBOUNCE_TICKS: debounce_reg = value[7:0];
			CFG_RESEND_PERIOD:  period_reg = value;
			default: ;
		endcase
	endtask

	task automatic queue_frame(input beep_t tone);
		logic [4:0][7:0] body;
		logic [7:0]      crc;
		frame_entry_t    e;
		body[IDX_HDR0] = HDR_BYTE0;
		body[IDX_HDR1] = HDR_BYTE1;
		body[IDX_HDR2] = HDR_BYTE2;
		body[IDX_FLAGS] = {flags_reg[7:3], lamp_on, flags_reg[1:0]};
		body[IDX_SPEED] = speed_reg;
		crc = maxim_crc(body);
		for (int k = 0; k < FRAME_BYTES; k++) begin
			e.data = (k == IDX_CRC) ? crc : body[k];
			e.pos = k[2:0];
			e.last = (k == IDX_CRC);
			e.tone = (k == IDX_HDR0) ? tone : BEEP_NONE;
			expected_bytes.push_back(e);
		end
	endtask

	task automatic predict_tick(input logic lvl);
		beep_t tone;
		tone = BEEP_NONE;
		tick_count++;
		if (lvl != last_raw)
			edge_seen = 1'b1;
		last_raw = lvl;
		if (since_sample != TICKS_MAX)
			since_sample++;
		if (since_sample > debounce_reg && edge_seen) begin
			since_sample = 8'd0;
			edge_seen = 1'b0;
			if (!lvl && stable_level) begin
				lamp_on = !lamp_on;
				send_due = 1'b1;
				tone = lamp_on ? BEEP_HIGH : BEEP_LOW;
				stable_level = 1'b0;
				toggle_count++;
			end else if (lvl && !stable_level) begin
				stable_level = 1'b1;
			end
		end
		if (repeat_count >= period_reg || send_due) begin
			queue_frame(tone);
			send_due = 1'b0;
			repeat_count = 16'd1;
		end else if (repeat_count != RESEND_MAX) begin
			repeat_count++;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_byte();
		frame_entry_t want;
		byte_count++;
		if (expected_bytes.size() == 0) begin
			err_count++;
			$display("%0t: unexpected byte, expected none actual %0h index %0d last %0b beep %0d",
				$time, frame_byte, byte_index, last_of_frame, beep);
		end else begin
			want = expected_bytes.pop_front();
			check_field("frame_byte", want.data, frame_byte);
			check_field("byte_index", {5'd0, want.pos}, {5'd0, byte_index});
			check_field("last_of_frame", {7'd0, want.last}, {7'd0, last_of_frame});
			check_field("beep", {6'd0, want.tone}, {6'd0, beep});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (out_valid && !out_stall)
				check_byte();
			if (cfg_valid && cfg_ready)
				apply_write(cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				predict_tick(button_level);
		end
		mismatches <= err_count;
		pending_bytes <= expected_bytes.size();
		ticks_seen <= tick_count;
		bytes_checked <= byte_count;
		toggles_seen <= toggle_count;
	end

endmodule

/* sim/debounced_toggle_crc8_frame_sender_core_tb.sv */
// testbench top for the debounced toggle crc8 frame sender: drives button ticks and
// register writes under random idling and gives the verdict
// depends on dtcs_pkg, debounced_toggle_crc8_frame_sender_core, dtcs_frame_checker
module debounced_toggle_crc8_frame_sender_core_tb;
	import dtcs_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  button_level = 1'b1;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            frame_byte;
	logic [2:0]            byte_index;
	logic                  last_of_frame;
	logic [1:0]            beep;

	int mismatches;
	int pending_bytes;
	int ticks_seen;
	int bytes_checked;
	int toggles_seen;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int writes_done = 0;
	int settings_done = 0;
	int run_left = 0;
	logic run_level = 1'b1;

	always #5 clk = ~clk;

	debounced_toggle_crc8_frame_sender_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.byte_index   (byte_index),
		.last_of_frame(last_of_frame),
		.beep         (beep)
	);

	dtcs_frame_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.byte_index   (byte_index),
		.last_of_frame(last_of_frame),
		.beep         (beep),
		.mismatches   (mismatches),
		.pending_bytes(pending_bytes),
		.ticks_seen   (ticks_seen),
		.bytes_checked(bytes_checked),
		.toggles_seen (toggles_seen)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// no transfer on any channel for too long ends the run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d bytes still expected", $time, pending_bytes);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= lvl;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		writes_done++;
	endtask

	task automatic write_all(input logic [7:0] flags, input logic [7:0] speed,
			input logic [7:0] debounce, input logic [15:0] period);
		settle();
		write_reg(CFG_OPTION_FLAGS, {8'd0, flags});
		write_reg(CFG_SPEED_LIMIT, {8'd0, speed});
		write_reg(CFG_DEBOUNCE_TICKS, {8'd0, debounce});
		write_reg(CFG_RESEND_PERIOD, period);
		settings_done++;
	endtask

	// mostly clean press and release holds around the debounce time, some bounce
	task automatic random_ticks(input logic [7:0] debounce, input int count);
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				if ($urandom_range(99) < 75) begin
					run_level = ~run_level;
					run_left = $urandom_range(int'(debounce) + 3, 1);
				end else begin
					run_level = 1'($urandom_range(1));
					run_left = $urandom_range(3, 1);
				end
			end
			run_left--;
			send_tick(run_level);
		end
	endtask

	task automatic run_phase(input logic [7:0] flags, input logic [7:0] speed,
			input logic [7:0] debounce, input logic [15:0] period, input int count);
		write_all(flags, speed, debounce, period);
		random_ticks(debounce, count);
	endtask

	initial begin
		logic [13:0] bounce_seq;
		bounce_seq = 14'b11111_0110_1100;
		send_idle_pct = 16;
		stall_pct = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first tick after reset sends with the reset register values
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);

		// short debounce: toggles both ways, release samples, equal samples, resends
		write_all(8'h00, 8'h00, 8'd1, 16'd4);
		for (int i = 0; i < 14; i++)
			send_tick(bounce_seq[i]);

		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1, 16'd7, 70);
		run_phase(8'hFF, 8'h00, 8'd3, 16'd0, 25);

		send_idle_pct = 50;
		stall_pct = 16;
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 16'd1, 60);
		run_phase(8'h00, 8'hFF, 8'd254, 16'd300, 150);
		// period lowered below the running count
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd3, 16'd1000, 30);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd3, 16'd5, 30);

		send_idle_pct = 0;
		stall_pct = 0;
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd255, 16'd200, 30);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(6)),
			16'($urandom_range(40, 1)), 70);

		settle();
		$display("Ran %0d ticks over %0d register settings (%0d writes)",
			ticks_seen, settings_done, writes_done);
		$display("Checked %0d frame bytes, %0d light toggles", bytes_checked, toggles_seen);
		if (mismatches == 0 && pending_bytes == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
